>>> hw/rtl/cartridge_disk_controller_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cartridge disk controller
// Shared property shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_DISK_CONTROLLER_MACROS_SVH
`define CARTRIDGE_DISK_CONTROLLER_MACROS_SVH

// An implication checked on every clock edge outside reset.
`define CDC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// An implication whose consequent is checked in the next cycle.
`define CDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/cdc_pkg.sv
// ----------------------------------------------------------------------------
// Cartridge disk controller package
// Geometry defaults, register codes, bit masks and the result and input item structures.
// ----------------------------------------------------------------------------
package cdc_pkg;

    localparam int CYLINDERS_DEF         = 203;
    localparam int SECTORS_PER_TRACK_DEF = 12;
    localparam int SECTOR_WORDS_DEF      = 256;

    typedef enum logic [1:0] {
        FN_READ   = 2'd0,
        FN_REG_WR = 2'd1,
        FN_STEP   = 2'd2,
        FN_NONE   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        RI_STATUS = 3'd0,
        RI_ERROR  = 3'd1,
        RI_CTRL   = 3'd2,
        RI_COUNT  = 3'd3,
        RI_ADDR   = 3'd4,
        RI_DADDR  = 3'd5,
        RI_BAD6   = 3'd6,
        RI_BAD7   = 3'd7
    } reg_idx_t;

    localparam logic [2:0] DF_RESET = 3'd0;
    localparam logic [2:0] DF_WRITE = 3'd1;
    localparam logic [2:0] DF_READ  = 3'd2;

    localparam logic [15:0] CS_GO    = 16'h0001;
    localparam logic [15:0] CS_IDE   = 16'h0040;
    localparam logic [15:0] CS_RDY   = 16'h0080;
    localparam logic [15:0] CS_HE    = 16'h4000;
    localparam logic [15:0] CS_ERR   = 16'h8000;
    localparam logic [15:0] CS_WMASK = 16'o017517;

    localparam logic [15:0] ER_NXS = 16'h0020;
    localparam logic [15:0] ER_NXC = 16'h0040;
    localparam logic [15:0] ER_NXD = 16'h0080;
    localparam logic [15:0] ER_NXM = 16'h0400;
    localparam logic [15:0] ER_OVR = 16'h4000;
    localparam logic [15:0] ER_DRE = 16'h8000;

    localparam logic [15:0] STATUS_FIXED = 16'h0880;

    typedef struct packed {
        logic [15:0] rdata;
        logic        bus_error;
        logic        irq;
        logic        ready_res;
        logic        moved;
        logic        is_write;
        logic [17:0] mem_addr;
        logic [20:0] disk_word;
        logic        sector_end;
    } result_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  reg_index;
        logic [15:0] wdata;
        logic        mem_ok;
        logic        disk_ok;
    } item_t;

endpackage

>>> hw/rtl/cdc_if.sv
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one payload word of width W with a source and a sink side.
// ----------------------------------------------------------------------------
interface cdc_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/cdc_in_if.sv
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel with the named fields of one input word.
// ----------------------------------------------------------------------------
interface cdc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [2:0]  reg_index;
    logic [15:0] wdata;
    logic        mem_ok;
    logic        disk_ok;

    modport source (output valid, output func, output reg_index, output wdata,
                    output mem_ok, output disk_ok, input ready);
    modport sink (input valid, input func, input reg_index, input wdata,
                  input mem_ok, input disk_ok, output ready);
endinterface

>>> hw/rtl/cdc_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel with the named fields of one result word.
// ----------------------------------------------------------------------------
interface cdc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] rdata;
    logic        bus_error;
    logic        irq;
    logic        ready_res;
    logic        moved;
    logic        is_write;
    logic [17:0] mem_addr;
    logic [20:0] disk_word;
    logic        sector_end;

    modport source (output valid, output rdata, output bus_error, output irq,
                    output ready_res, output moved, output is_write, output mem_addr,
                    output disk_word, output sector_end, input ready);
    modport sink (input valid, input rdata, input bus_error, input irq,
                  input ready_res, input moved, input is_write, input mem_addr,
                  input disk_word, input sector_end, output ready);
endinterface

>>> hw/rtl/cdc_core.sv
// ----------------------------------------------------------------------------
// Controller register file and transfer sequencer
// Applies one accepted word per cycle to the register state and forms
// its result.
// ----------------------------------------------------------------------------
module cdc_core
    import cdc_pkg::*;
#(
    parameter int CYLINDERS         = CYLINDERS_DEF,
    parameter int SECTORS_PER_TRACK = SECTORS_PER_TRACK_DEF,
    parameter int SECTOR_WORDS      = SECTOR_WORDS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  logic    pack_present,
    output result_t res
);

    localparam logic [7:0] CYL_LIM  = 8'(CYLINDERS);
    localparam logic [3:0] SEC_LIM  = 4'(SECTORS_PER_TRACK);
    localparam logic [8:0] WORD_LIM = 9'(SECTOR_WORDS);

    logic        rw_ready_reg, rw_ready_next;
    logic [15:0] err_reg, err_next;
    logic [15:0] ctrl_reg, ctrl_next;
    logic [15:0] wc_reg, wc_next;
    logic [17:0] ba_reg, ba_next;
    logic [17:0] wa_reg, wa_next;
    logic [2:0]  drv_reg, drv_next;
    logic [7:0]  cyl_reg, cyl_next;
    logic        head_reg, head_next;
    logic [3:0]  sec_reg, sec_next;
    logic [7:0]  wis_reg, wis_next;
    logic        busy_reg, busy_next;
    logic        wdir_reg, wdir_next;

    logic [2:0]  fn;
    logic        last;
    logic [15:0] wc_inc;
    logic [17:0] wa_inc;
    logic [3:0]  sec_inc;
    logic [20:0] track;
    logic        do_finish;
    logic        do_fail;
    logic [15:0] fail_bits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rw_ready_reg <= 1'b1;
            err_reg      <= '0;
            ctrl_reg     <= CS_RDY;
            wc_reg       <= '0;
            ba_reg       <= '0;
            wa_reg       <= '0;
            drv_reg      <= '0;
            cyl_reg      <= '0;
            head_reg     <= 1'b0;
            sec_reg      <= '0;
            wis_reg      <= '0;
            busy_reg     <= 1'b0;
            wdir_reg     <= 1'b0;
        end
        else if (step)
        begin
            rw_ready_reg <= rw_ready_next;
            err_reg      <= err_next;
            ctrl_reg     <= ctrl_next;
            wc_reg       <= wc_next;
            ba_reg       <= ba_next;
            wa_reg       <= wa_next;
            drv_reg      <= drv_next;
            cyl_reg      <= cyl_next;
            head_reg     <= head_next;
            sec_reg      <= sec_next;
            wis_reg      <= wis_next;
            busy_reg     <= busy_next;
            wdir_reg     <= wdir_next;
        end
    end

    assign wc_inc = wc_reg + 16'd1;
    assign wa_inc = wa_reg + 18'd2;
    assign sec_inc = sec_reg + 4'd1;
    assign last = ({1'b0, wis_reg} + 9'd1 >= WORD_LIM) || (wc_inc == 16'd0);
    assign track = 21'(({12'd0, cyl_reg, head_reg} * 21'(SECTORS_PER_TRACK)
                       + 21'(sec_reg)) * 21'(SECTOR_WORDS) + 21'(wis_reg));

    always_comb
    begin
        rw_ready_next = rw_ready_reg;
        err_next      = err_reg;
        ctrl_next     = ctrl_reg;
        wc_next       = wc_reg;
        ba_next       = ba_reg;
        wa_next       = wa_reg;
        drv_next      = drv_reg;
        cyl_next      = cyl_reg;
        head_next     = head_reg;
        sec_next      = sec_reg;
        wis_next      = wis_reg;
        busy_next     = busy_reg;
        wdir_next     = wdir_reg;
        res           = '0;
        do_finish     = 1'b0;
        do_fail       = 1'b0;
        fail_bits     = '0;
        fn            = item.wdata[3:1];

        if ((item.func == FN_READ || item.func == FN_REG_WR) && item.reg_index > RI_DADDR)
        begin
            res.bus_error = 1'b1;
        end
        else if (item.func == FN_READ)
        begin
            unique case (item.reg_index)
                RI_STATUS: res.rdata = STATUS_FIXED | {9'd0, rw_ready_reg, 2'd0, sec_reg};
                RI_ERROR:  res.rdata = err_reg;
                RI_CTRL:   res.rdata = ctrl_reg | {10'd0, ba_reg[17:16], 4'd0};
                RI_COUNT:  res.rdata = wc_reg;
                RI_ADDR:   res.rdata = ba_reg[15:0];
                default:   res.rdata = {drv_reg, cyl_reg, head_reg, sec_reg};
            endcase
        end
        else if (item.func == FN_REG_WR && !busy_reg)
        begin
            unique case (item.reg_index)
                RI_CTRL:
                begin
                    ba_next[17:16] = item.wdata[5:4];
                    ctrl_next = (ctrl_reg & ~CS_WMASK) | (item.wdata & CS_WMASK & ~CS_GO);
                    if (item.wdata[0])
                    begin
                        ctrl_next = ctrl_next & ~(CS_RDY | CS_ERR | CS_HE);
                        rw_ready_next = 1'b0;
                        err_next = '0;
                        if (fn == DF_RESET)
                        begin
                            rw_ready_next = 1'b1;
                            err_next  = '0;
                            ctrl_next = CS_RDY;
                            wc_next   = '0;
                            ba_next   = '0;
                            wa_next   = '0;
                            drv_next  = '0;
                            cyl_next  = '0;
                            head_next = 1'b0;
                            sec_next  = '0;
                            wdir_next = 1'b0;
                            do_finish = 1'b1;
                        end
                        else if (fn != DF_WRITE && fn != DF_READ)
                            do_finish = 1'b1;
                        else if (!pack_present)
                        begin
                            do_fail = 1'b1;
                            fail_bits = ER_DRE;
                        end
                        else if (drv_reg != 3'd0)
                        begin
                            do_fail = 1'b1;
                            fail_bits = ER_NXD;
                        end
                        else if (cyl_reg >= CYL_LIM)
                        begin
                            do_fail = 1'b1;
                            fail_bits = ER_NXC;
                        end
                        else if (sec_reg >= SEC_LIM)
                        begin
                            do_fail = 1'b1;
                            fail_bits = ER_NXS;
                        end
                        else if (wc_reg == 16'd0)
                            do_finish = 1'b1;
                        else
                        begin
                            busy_next = 1'b1;
                            wdir_next = (fn == DF_WRITE);
                            wa_next   = {item.wdata[5:4], ba_reg[15:0]};
                            wis_next  = '0;
                        end
                    end
                end
                RI_COUNT: wc_next = item.wdata;
                RI_ADDR:  ba_next[15:0] = item.wdata;
                RI_DADDR:
                begin
                    drv_next  = item.wdata[15:13];
                    cyl_next  = item.wdata[12:5];
                    head_next = item.wdata[4];
                    sec_next  = item.wdata[3:0];
                end
                default: ;
            endcase
        end
        else if (item.func == FN_STEP && busy_reg)
        begin
            if (wis_reg == 8'd0 && cyl_reg >= CYL_LIM)
            begin
                do_fail = 1'b1;
                fail_bits = ER_OVR;
            end
            else if (wis_reg == 8'd0 && !wdir_reg && !item.disk_ok)
            begin
                do_fail = 1'b1;
                fail_bits = ER_DRE;
            end
            else if (!item.mem_ok)
            begin
                do_fail = 1'b1;
                fail_bits = ER_NXM;
            end
            else
            begin
                res.moved     = 1'b1;
                res.is_write  = wdir_reg;
                res.mem_addr  = wa_reg;
                res.disk_word = track;
                wa_next = wa_inc;
                wc_next = wc_inc;
                if (!last)
                    wis_next = wis_reg + 8'd1;
                else
                begin
                    res.sector_end = 1'b1;
                    if (wdir_reg && !item.disk_ok)
                    begin
                        do_fail = 1'b1;
                        fail_bits = ER_DRE;
                    end
                    else
                    begin
                        ba_next  = wa_inc;
                        wis_next = '0;
                        if (sec_inc >= SEC_LIM)
                        begin
                            sec_next  = '0;
                            head_next = ~head_reg;
                            if (head_reg)
                                cyl_next = cyl_reg + 8'd1;
                        end
                        else
                            sec_next = sec_inc;
                        if (wc_inc == 16'd0)
                            do_finish = 1'b1;
                    end
                end
            end
        end

        if (do_fail)
        begin
            err_next  = err_next | fail_bits;
            ctrl_next = ctrl_next | CS_ERR | CS_HE;
        end
        if (do_fail || do_finish)
        begin
            rw_ready_next = 1'b1;
            ctrl_next = ctrl_next | CS_RDY;
            busy_next = 1'b0;
            wis_next  = '0;
            res.irq   = |(ctrl_next & CS_IDE);
        end
        res.ready_res = |(ctrl_next & CS_RDY);
    end

endmodule

>>> hw/rtl/cdc_out_reg.sv
// ----------------------------------------------------------------------------
// Result skid register
// Two-entry output buffer so the input side can take one more result while a
// result waits to be taken.
// ----------------------------------------------------------------------------
module cdc_out_reg
    import cdc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    result_t main_reg;
    result_t skid_reg;
    logic    main_vld_reg;
    logic    skid_vld_reg;

    assign in_ready  = !skid_vld_reg;
    assign out_valid = main_vld_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (!main_vld_reg || out_ready)
            begin
                main_vld_reg <= skid_vld_reg || in_valid;
                skid_vld_reg <= 1'b0;
            end
            else if (in_valid && !skid_vld_reg)
                skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_vld_reg || out_ready)
            main_reg <= skid_vld_reg ? skid_reg : in_data;
        else if (in_valid && !skid_vld_reg)
            skid_reg <= in_data;
    end

endmodule

>>> hw/rtl/cartridge_disk_controller.sv
// A result is registered in the result buffer's main register, or first in its skid
// register while the main one is held, before it is offered. Throughput: one word per
// cycle while the skid register is free; the register update is one pass of logic.
// A two-entry result buffer takes one more word in while a result is held.
// Reset (rst_n low) clears the state: ready set, control 0x80, pack present set.
module cartridge_disk_controller
    import cdc_pkg::*;
#(
    parameter int CYLINDERS         = CYLINDERS_DEF,
    parameter int SECTORS_PER_TRACK = SECTORS_PER_TRACK_DEF,
    parameter int SECTOR_WORDS      = SECTOR_WORDS_DEF
)
(
    input logic  clk,
    input logic  rst_n,
    cdc_in_if.sink   in_ch,
    cdc_out_if.source out_ch,
    cdc_if.sink      cfg
);

    logic    pack_reg;
    logic    step;
    item_t   item;
    result_t res;
    result_t res_out;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pack_reg <= 1'b1;
        else if (cfg.valid)
            pack_reg <= cfg.data[0];
    end

    assign step = in_ch.valid && in_ch.ready;
    assign item = '{func: in_ch.func, reg_index: in_ch.reg_index, wdata: in_ch.wdata,
                    mem_ok: in_ch.mem_ok, disk_ok: in_ch.disk_ok};

    cdc_core #(
        .CYLINDERS(CYLINDERS),
        .SECTORS_PER_TRACK(SECTORS_PER_TRACK),
        .SECTOR_WORDS(SECTOR_WORDS)
    ) u_core (
        .clk(clk),
        .rst_n(rst_n),
        .step(step),
        .item(item),
        .pack_present(pack_reg),
        .res(res)
    );

    cdc_out_reg u_out (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(step),
        .in_ready(in_ch.ready),
        .in_data(res),
        .out_valid(out_ch.valid),
        .out_ready(out_ch.ready),
        .out_data(res_out)
    );

    assign out_ch.rdata      = res_out.rdata;
    assign out_ch.bus_error  = res_out.bus_error;
    assign out_ch.irq        = res_out.irq;
    assign out_ch.ready_res  = res_out.ready_res;
    assign out_ch.moved      = res_out.moved;
    assign out_ch.is_write   = res_out.is_write;
    assign out_ch.mem_addr   = res_out.mem_addr;
    assign out_ch.disk_word  = res_out.disk_word;
    assign out_ch.sector_end = res_out.sector_end;

endmodule

>>> hw/rtl/cdc_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the controller ports for result consistency.
// ----------------------------------------------------------------------------
`include "cartridge_disk_controller_macros.svh"

module cdc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        moved,
    input logic        sector_end,
    input logic        bus_error,
    input logic [15:0] rdata,
    input logic        is_write
);

    `CDC_ASSERT_IMP(a_end_moved, out_valid && sector_end, moved, "sector end without a word")
    `CDC_ASSERT_IMP(a_berr_zero, out_valid && bus_error, rdata == 16'd0 && !moved,
        "bus error with data")
    `CDC_ASSERT_IMP(a_dir_moved, out_valid && is_write, moved, "direction set without a word")
    `CDC_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(moved),
        "stalled result changed")
    // An accepted word always leaves a result on offer in the next cycle.
    `CDC_ASSERT_NEXT(a_accept_res, in_valid && in_ready, out_valid, "accepted word lost")

endmodule

bind cartridge_disk_controller cdc_checker u_cdc_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .moved(out_ch.moved),
    .sector_end(out_ch.sector_end),
    .bus_error(out_ch.bus_error),
    .rdata(out_ch.rdata),
    .is_write(out_ch.is_write)
);
